### sv/qau_pkg.sv
// Shared types and constants for the quaternion arithmetic unit.
// No dependencies; imported by the interfaces, the top level and the checker.
package qau_pkg;

  localparam int unsigned COMP_W  = 32;  // Q3.28 component width
  localparam int unsigned FRAC_W  = 28;  // fraction bits, 1.0 = 2**FRAC_W
  localparam int unsigned CMD_W   = 2;

  typedef logic signed [COMP_W-1:0] comp_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_MUL  = 2'd0,
    CMD_CONJ = 2'd1,
    CMD_NORM = 2'd2,
    CMD_LEN  = 2'd3
  } cmd_e;

  localparam comp_t COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
  localparam comp_t COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};

endpackage

### sv/qau_if.sv
// Handshake channels of the quaternion arithmetic unit (input and result words).
// Depends on qau_pkg.
interface qau_in_if import qau_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  comp_t            a_w, a_x, a_y, a_z;
  comp_t            b_w, b_x, b_y, b_z;

  modport source (output valid, cmd, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                  input ready);
  modport sink   (input valid, cmd, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                  output ready);
endinterface

interface qau_out_if import qau_pkg::*; ();
  logic              valid;
  logic              ready;
  comp_t             r_w, r_x, r_y, r_z;
  logic [COMP_W-1:0] magnitude;
  logic              zero_length;

  modport source (output valid, r_w, r_x, r_y, r_z, magnitude, zero_length,
                  input ready);
  modport sink   (input valid, r_w, r_x, r_y, r_z, magnitude, zero_length,
                  output ready);
endinterface

### sv/quaternion_arithmetic_unit_top.sv
// Quaternion arithmetic unit: Hamilton product, conjugate, normalize, length.
// Depends on qau_pkg and the qau_in_if / qau_out_if channels.
// Throughput: one word per cycle unless the output stalls; every command takes
// the same path through 70 register stages (32 one-bit square root steps, 30
// one-bit divider steps in four lanes), each taking a new word per cycle.
// Reset (rst_ni low, asynchronous) empties the pipeline; data regs not reset.
module quaternion_arithmetic_unit_top import qau_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  qau_in_if.sink   in_i,
  qau_out_if.source out_o
);

  localparam int unsigned SQ_STEPS = 32;
  localparam int unsigned DV_STEPS = 30;
  localparam int unsigned SQ_BASE  = 5;
  localparam int unsigned DV_BASE  = SQ_BASE + SQ_STEPS + 1;
  localparam int unsigned FIN      = DV_BASE + DV_STEPS + 1;
  localparam int unsigned NS       = FIN + 1;

  typedef logic signed [63:0] p64_t;
  typedef logic signed [65:0] s66_t;

  typedef struct packed {
    cmd_e             cmd;
    comp_t [3:0]      a;
    comp_t [3:0]      b;
  } s0_t;

  typedef struct packed {
    cmd_e              cmd;
    comp_t [3:0]       a;
    comp_t [3:0]       b;
    logic [3:0][31:0]  absa;
    logic [31:0]       m;
  } s1_t;

  typedef struct packed {
    cmd_e              cmd;
    comp_t [3:0]       a;
    comp_t [3:0]       b;
    logic [3:0][31:0]  op;
    logic [3:0]        neg;
    logic              zero;
    comp_t [3:0]       res;
  } s2_t;

  typedef struct packed {
    cmd_e              cmd;
    p64_t [15:0]       prod;
    logic [3:0][63:0]  sq;
    logic [3:0][31:0]  op;
    logic [3:0]        neg;
    logic              zero;
    comp_t [3:0]       res;
  } s3_t;

  typedef struct packed {
    cmd_e              cmd;
    s66_t [3:0]        msum;
    logic [64:0]       n;
    logic [3:0][31:0]  op;
    logic [3:0]        neg;
    logic              zero;
    comp_t [3:0]       res;
  } s4_t;

  typedef struct packed {
    cmd_e              cmd;
    comp_t [3:0]       res;
    logic [3:0][31:0]  op;
    logic [3:0]        neg;
    logic              zero;
    logic              over;
    logic [63:0]       rad;
    logic [32:0]       rem;
    logic [31:0]       root;
  } sq_t;

  typedef struct packed {
    cmd_e              cmd;
    comp_t [3:0]       res;
    logic [3:0]        neg;
    logic              zero;
    logic [31:0]       mag;
    logic [31:0]       len;
    logic [3:0][29:0]  nlo;
    logic [3:0][32:0]  drem;
    logic [3:0][29:0]  q;
  } dv_t;

  typedef struct packed {
    comp_t [3:0]  r;
    logic [31:0]  mag;
    logic         zl;
  } fin_t;

  function automatic comp_t neg_sat(comp_t v);
    return (v == COMP_MIN) ? COMP_MAX : comp_t'(-v);
  endfunction

  // round Q9.56 to Q3.28, ties toward +inf, then saturate
  function automatic comp_t round_sat(s66_t s);
    logic [65:0] t;
    logic [37:0] rr;
    t  = 66'(s) + (66'(1) << (FRAC_W - 1));
    rr = t[65:FRAC_W];
    if (rr[37:31] == {7{rr[31]}}) return comp_t'(rr[31:0]);
    return rr[37] ? COMP_MIN : COMP_MAX;
  endfunction

  function automatic s66_t ext(p64_t p);
    return {{2{p[63]}}, p};
  endfunction

  // ---------------- handshake ----------------
  logic [NS:0]   rdy;
  logic [NS-1:0] v_q;
  logic [NS-1:0] v_in;

  assign rdy[NS] = out_o.ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign v_in = {v_q[NS-2:0], in_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) v_q[k] <= v_in[k];
      end
    end
  end

  assign in_i.ready = rdy[0];

  // ---------------- stage 0: capture ----------------
  s0_t s0_q;
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s0_q.cmd <= cmd_e'(in_i.cmd);
      s0_q.a   <= {in_i.a_z, in_i.a_y, in_i.a_x, in_i.a_w};
      s0_q.b   <= {in_i.b_z, in_i.b_y, in_i.b_x, in_i.b_w};
    end
  end

  // ---------------- stage 1: magnitudes, max ----------------
  s1_t s1_d, s1_q;
  always_comb begin
    logic [31:0] m01, m23;
    s1_d.cmd = s0_q.cmd;
    s1_d.a   = s0_q.a;
    s1_d.b   = s0_q.b;
    for (int i = 0; i < 4; i++) begin
      s1_d.absa[i] = s0_q.a[i][31] ? 32'(~s0_q.a[i] + 32'd1) : 32'(s0_q.a[i]);
    end
    m01    = (s1_d.absa[0] > s1_d.absa[1]) ? s1_d.absa[0] : s1_d.absa[1];
    m23    = (s1_d.absa[2] > s1_d.absa[3]) ? s1_d.absa[2] : s1_d.absa[3];
    s1_d.m = (m01 > m23) ? m01 : m23;
  end
  always_ff @(posedge clk_i) begin
    if (rdy[1]) s1_q <= s1_d;
  end

  // ---------------- stage 2: scale shift, conjugate ----------------
  s2_t s2_d, s2_q;
  always_comb begin
    logic [4:0] sh;
    sh = '0;
    // shift that brings the largest magnitude into [2^30, 2^31); none if bit 31 is set
    for (int i = 0; i < 31; i++) begin
      if (s1_q.m[i]) sh = 5'(30 - i);
    end
    if (s1_q.m[31]) sh = '0;
    s2_d.cmd  = s1_q.cmd;
    s2_d.a    = s1_q.a;
    s2_d.b    = s1_q.b;
    s2_d.zero = (s1_q.m == '0);
    for (int i = 0; i < 4; i++) begin
      s2_d.op[i]  = (s1_q.cmd == CMD_NORM) ? (s1_q.absa[i] << sh) : s1_q.absa[i];
      s2_d.neg[i] = s1_q.a[i][31];
    end
    s2_d.res[0] = s1_q.a[0];
    for (int i = 1; i < 4; i++) s2_d.res[i] = neg_sat(s1_q.a[i]);
  end
  always_ff @(posedge clk_i) begin
    if (rdy[2]) s2_q <= s2_d;
  end

  // ---------------- stage 3: products and squares ----------------
  s3_t s3_d, s3_q;
  always_comb begin
    s3_d.cmd  = s2_q.cmd;
    s3_d.op   = s2_q.op;
    s3_d.neg  = s2_q.neg;
    s3_d.zero = s2_q.zero;
    s3_d.res  = s2_q.res;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        s3_d.prod[4*i+j] = p64_t'($signed(s2_q.a[i]) * $signed(s2_q.b[j]));
      end
      s3_d.sq[i] = 64'(s2_q.op[i]) * 64'(s2_q.op[i]);
    end
  end
  always_ff @(posedge clk_i) begin
    if (rdy[3]) s3_q <= s3_d;
  end

  // ---------------- stage 4: sums ----------------
  s4_t s4_d, s4_q;
  always_comb begin
    s4_d.cmd  = s3_q.cmd;
    s4_d.op   = s3_q.op;
    s4_d.neg  = s3_q.neg;
    s4_d.zero = s3_q.zero;
    s4_d.res  = s3_q.res;
    s4_d.msum[0] = ext(s3_q.prod[0]) - ext(s3_q.prod[5])
                 - ext(s3_q.prod[10]) - ext(s3_q.prod[15]);
    s4_d.msum[1] = ext(s3_q.prod[1]) + ext(s3_q.prod[4])
                 + ext(s3_q.prod[11]) - ext(s3_q.prod[14]);
    s4_d.msum[2] = ext(s3_q.prod[2]) + ext(s3_q.prod[8])
                 + ext(s3_q.prod[13]) - ext(s3_q.prod[7]);
    s4_d.msum[3] = ext(s3_q.prod[3]) + ext(s3_q.prod[12])
                 + ext(s3_q.prod[6]) - ext(s3_q.prod[9]);
    s4_d.n = 65'(s3_q.sq[0]) + 65'(s3_q.sq[1]) + 65'(s3_q.sq[2]) + 65'(s3_q.sq[3]);
  end
  always_ff @(posedge clk_i) begin
    if (rdy[4]) s4_q <= s4_d;
  end

  // ---------------- stage 5: round product, load root radicand ----------------
  sq_t sq_q [SQ_STEPS+1];
  sq_t sq_init;
  always_comb begin
    sq_init.cmd  = s4_q.cmd;
    sq_init.op   = s4_q.op;
    sq_init.neg  = s4_q.neg;
    sq_init.zero = s4_q.zero;
    sq_init.res  = s4_q.res;
    if (s4_q.cmd == CMD_MUL) begin
      for (int i = 0; i < 4; i++) sq_init.res[i] = round_sat(s4_q.msum[i]);
    end
    // normalize works on a quarter of the scaled sum
    sq_init.rad  = (s4_q.cmd == CMD_NORM) ? {1'b0, s4_q.n[64:2]} : s4_q.n[63:0];
    sq_init.over = (s4_q.cmd == CMD_LEN) && s4_q.n[64];
    sq_init.rem  = '0;
    sq_init.root = '0;
  end
  always_ff @(posedge clk_i) begin
    if (rdy[SQ_BASE]) sq_q[0] <= sq_init;
  end

  // ---------------- square root, one root bit per stage ----------------
  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
    sq_t         nxt;
    logic [34:0] t, trial;
    always_comb begin
      t     = {sq_q[j].rem, sq_q[j].rad[63:62]};
      trial = {1'b0, sq_q[j].root, 2'b01};
      nxt     = sq_q[j];
      nxt.rad = {sq_q[j].rad[61:0], 2'b00};
      if (t >= trial) begin
        nxt.rem  = 33'(t - trial);
        nxt.root = {sq_q[j].root[30:0], 1'b1};
      end else begin
        nxt.rem  = t[32:0];
        nxt.root = {sq_q[j].root[30:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (rdy[SQ_BASE+j+1]) sq_q[j+1] <= nxt;
    end
  end

  // ---------------- root rounding, divider load ----------------
  dv_t dv_q [DV_STEPS+1];
  dv_t dv_init;
  always_comb begin
    sq_t         sl;
    logic [32:0] len33;
    logic [58:0] num;
    sl    = sq_q[SQ_STEPS];
    len33 = {1'b0, sl.root} + 33'(sl.rem > {1'b0, sl.root});
    dv_init.cmd  = sl.cmd;
    dv_init.res  = sl.res;
    dv_init.neg  = sl.neg;
    dv_init.zero = sl.zero;
    dv_init.len  = len33[31:0];
    if (sl.cmd != CMD_LEN)            dv_init.mag = '0;
    else if (sl.over || len33[32])    dv_init.mag = '1;
    else                              dv_init.mag = len33[31:0];
    for (int i = 0; i < 4; i++) begin
      num = {sl.op[i], 27'b0} + 59'(len33[31:1]);
      dv_init.drem[i] = {4'b0, num[58:30]};
      dv_init.nlo[i]  = num[29:0];
      dv_init.q[i]    = '0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (rdy[DV_BASE]) dv_q[0] <= dv_init;
  end

  // ---------------- divider, one quotient bit per stage, four lanes ----------------
  for (genvar j = 0; j < DV_STEPS; j++) begin : g_dv
    dv_t nxt;
    always_comb begin
      logic [32:0] t;
      nxt = dv_q[j];
      for (int i = 0; i < 4; i++) begin
        t          = {dv_q[j].drem[i][31:0], dv_q[j].nlo[i][29]};
        nxt.nlo[i] = {dv_q[j].nlo[i][28:0], 1'b0};
        if (t >= {1'b0, dv_q[j].len}) begin
          nxt.drem[i] = t - {1'b0, dv_q[j].len};
          nxt.q[i]    = {dv_q[j].q[i][28:0], 1'b1};
        end else begin
          nxt.drem[i] = t;
          nxt.q[i]    = {dv_q[j].q[i][28:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (rdy[DV_BASE+j+1]) dv_q[j+1] <= nxt;
    end
  end

  // ---------------- result select ----------------
  fin_t fin_d, fin_q;
  always_comb begin
    dv_t   dl;
    comp_t qv;
    dl        = dv_q[DV_STEPS];
    fin_d.r   = '0;
    fin_d.mag = '0;
    fin_d.zl  = 1'b0;
    case (dl.cmd)
      CMD_MUL, CMD_CONJ: fin_d.r = dl.res;
      CMD_NORM: begin
        if (dl.zero) begin
          fin_d.zl = 1'b1;
        end else begin
          for (int i = 0; i < 4; i++) begin
            qv         = comp_t'({2'b00, dl.q[i]});
            fin_d.r[i] = dl.neg[i] ? comp_t'(-qv) : qv;
          end
        end
      end
      default: fin_d.mag = dl.mag;
    endcase
  end
  always_ff @(posedge clk_i) begin
    if (rdy[FIN]) fin_q <= fin_d;
  end

  assign out_o.valid       = v_q[FIN];
  assign out_o.r_w         = fin_q.r[0];
  assign out_o.r_x         = fin_q.r[1];
  assign out_o.r_y         = fin_q.r[2];
  assign out_o.r_z         = fin_q.r[3];
  assign out_o.magnitude   = fin_q.mag;
  assign out_o.zero_length = fin_q.zl;

endmodule

### sv/qau_checker.sv
// Port-level checks for the quaternion arithmetic unit, bound to the top level.
// Depends on qau_pkg and quaternion_arithmetic_unit_top.
module qau_checker import qau_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input comp_t             r_w_i,
  input comp_t             r_x_i,
  input comp_t             r_y_i,
  input comp_t             r_z_i,
  input logic [COMP_W-1:0] magnitude_i,
  input logic              zero_length_i
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(r_w_i) && $stable(r_x_i)
      && $stable(r_y_i) && $stable(r_z_i) && $stable(magnitude_i))
    else $error("result word changed under stall");

  // input backpressure only when the pipeline is full behind a stalled output
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled with room in pipeline");

  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && zero_length_i |-> r_w_i == 0 && r_x_i == 0 && r_y_i == 0
      && r_z_i == 0 && magnitude_i == 0)
    else $error("zero-length result not cleared");

  a_mag_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && magnitude_i != 0 |-> r_w_i == 0 && r_x_i == 0 && r_y_i == 0
      && r_z_i == 0 && !zero_length_i)
    else $error("length result carries quaternion data");

endmodule

bind quaternion_arithmetic_unit_top qau_checker u_qau_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .r_w_i         (out_o.r_w),
  .r_x_i         (out_o.r_x),
  .r_y_i         (out_o.r_y),
  .r_z_i         (out_o.r_z),
  .magnitude_i   (out_o.magnitude),
  .zero_length_i (out_o.zero_length)
);
